// ----- src/iff_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared widths, conversion kind codes, ASCII constants and a digit-to-character function.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 2;
    localparam int FWIDTH_W  = 8;
    localparam int CHAR_W    = 7;
    localparam int DEC_DIGS  = 10;
    localparam int BCD_W     = 4 * DEC_DIGS;

    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [FWIDTH_W-1:0] t_fwidth;
    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [BCD_W-1:0]    t_bcd;

    localparam t_kind KIND_SDEC = 2'd0;
    localparam t_kind KIND_UDEC = 2'd1;
    localparam t_kind KIND_HEX  = 2'd2;

    localparam t_char CHAR_MINUS = 7'h2D;
    localparam t_char CHAR_SPACE = 7'h20;
    localparam t_char CHAR_ZERO  = 7'h30;

    function automatic t_char digit_char(input logic [3:0] d);
        t_char c;
        case (d)
            4'h0: c = 7'h30;
            4'h1: c = 7'h31;
            4'h2: c = 7'h32;
            4'h3: c = 7'h33;
            4'h4: c = 7'h34;
            4'h5: c = 7'h35;
            4'h6: c = 7'h36;
            4'h7: c = 7'h37;
            4'h8: c = 7'h38;
            4'h9: c = 7'h39;
            4'hA: c = 7'h41;
            4'hB: c = 7'h42;
            4'hC: c = 7'h43;
            4'hD: c = 7'h44;
            4'hE: c = 7'h45;
            default: c = 7'h46;
        endcase
        return c;
    endfunction

endpackage

// ----- src/iff_in_if.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter input channel
// One beat carries a value and its formatting request.
// ----------------------------------------------------------------------------
interface iff_in_if;
    logic               valid;
    logic               ready;
    iff_pkg::t_value    value;
    iff_pkg::t_kind     conversion_kind;
    iff_pkg::t_fwidth   field_width;
    logic               zero_fill;

    modport source (output valid, value, conversion_kind, field_width, zero_fill,
                    input ready);
    modport sink   (input valid, value, conversion_kind, field_width, zero_fill,
                    output ready);
endinterface

// ----- src/iff_out_if.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter output channel
// One beat carries one ASCII character and an end-of-field flag.
// ----------------------------------------------------------------------------
interface iff_out_if;
    logic             valid;
    logic             ready;
    iff_pkg::t_char   out_char;
    logic             last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ----- src/integer_field_formatter.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter
// Decimal fields pass through a bit-serial double-dabble loop (S_CONV) and then
// a sizing state (S_PREP); hex fields go straight to the sizing state.
// Throughput: one field at a time, then one character per cycle while the
// sink is ready.
// Reset returns the controller to idle with the input ready and no beat shown.
// ----------------------------------------------------------------------------
module integer_field_formatter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iff_in_if.sink    i_in,
    iff_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_LEAD = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_SIGN = 3'd5;
    localparam logic [2:0] S_DIG  = 3'd6;

    logic [2:0]         r_state, n_state;
    iff_pkg::t_value    r_bin, n_bin;
    iff_pkg::t_bcd      r_bcd, n_bcd;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_zf, n_zf;
    iff_pkg::t_fwidth   r_width, n_width;
    logic [3:0]         r_idx, n_idx;
    logic [3:0]         r_pad, n_pad;

    logic               in_fire;
    logic               out_fire;
    logic               is_dec;
    logic               in_neg;
    iff_pkg::t_bcd      bcd_adj;
    logic [3:0]         top_idx;
    logic [9:0]         pad_calc;
    logic [3:0]         pad_new;
    logic [3:0]         cur_nib;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    assign is_dec = (i_in.conversion_kind == iff_pkg::KIND_SDEC) ||
                    (i_in.conversion_kind == iff_pkg::KIND_UDEC);
    assign in_neg = (i_in.conversion_kind == iff_pkg::KIND_SDEC) && i_in.value[31];

    always_comb begin
        for (int i = 0; i < iff_pkg::DEC_DIGS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ?
                                r_bcd[4*i +: 4] + 4'd3 : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        top_idx = 4'd0;
        for (int i = 1; i < iff_pkg::DEC_DIGS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                top_idx = 4'(i);
            end
        end
    end

    // Signed pad count: width - (digits - 1) - sign; padding only for 2..15.
    assign pad_calc = {2'b00, r_width} - {6'd0, top_idx} - {9'd0, r_neg};
    assign pad_new  = ((pad_calc[9:4] == 6'd0) && (pad_calc[3:0] >= 4'd2)) ?
                      pad_calc[3:0] - 4'd1 : 4'd0;

    assign cur_nib = r_bcd[{r_idx, 2'b00} +: 4];

    always_comb begin
        o_out.valid     = r_state inside {S_LEAD, S_PAD, S_SIGN, S_DIG};
        o_out.last_char = (r_state == S_DIG) && (r_idx == 4'd0);
        case (r_state)
            S_LEAD, S_SIGN: o_out.out_char = iff_pkg::CHAR_MINUS;
            S_PAD:          o_out.out_char = r_zf ? iff_pkg::CHAR_ZERO : iff_pkg::CHAR_SPACE;
            default:        o_out.out_char = iff_pkg::digit_char(cur_nib);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zf    = r_zf;
        n_width = r_width;
        n_idx   = r_idx;
        n_pad   = r_pad;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_neg   = in_neg;
                    n_zf    = i_in.zero_fill;
                    n_width = i_in.field_width;
                    n_cnt   = 5'd0;
                    n_bin   = in_neg ? 32'd0 - i_in.value : i_in.value;
                    if (is_dec) begin
                        n_bcd   = '0;
                        n_state = S_CONV;
                    end else begin
                        n_bcd   = {8'd0, i_in.value};
                        n_state = S_PREP;
                    end
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[iff_pkg::BCD_W-2:0], r_bin[31]};
                n_bin = {r_bin[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_idx = top_idx;
                n_pad = pad_new;
                if (r_neg && r_zf) begin
                    n_state = S_LEAD;
                end else if (pad_new != 4'd0) begin
                    n_state = S_PAD;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_DIG;
                end
            end
            S_LEAD: begin
                if (out_fire) begin
                    n_state = (r_pad != 4'd0) ? S_PAD : S_DIG;
                end
            end
            S_PAD: begin
                if (out_fire) begin
                    n_pad = r_pad - 4'd1;
                    if (r_pad == 4'd1) begin
                        n_state = (r_neg && !r_zf) ? S_SIGN : S_DIG;
                    end
                end
            end
            S_SIGN: begin
                if (out_fire) begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (out_fire) begin
                    if (r_idx == 4'd0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_zf    <= n_zf;
        r_width <= n_width;
        r_idx   <= n_idx;
        r_pad   <= n_pad;
    end

endmodule

// ----- src/iff_checker.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter port checker
// Checks the sequencing of fields and characters seen at the ports.
// ----------------------------------------------------------------------------
module iff_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input iff_pkg::t_char     i_out_char,
    input logic               i_out_last
);

    // A new field is never taken while characters of the previous one are shown.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a character beat is pending");

    // The first character of a field is never shown right after the field is accepted.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("character shown right after a field was accepted");

    // The block returns to accepting fields right after the final character.
    a_free_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (i_in_ready && !i_out_valid))
        else $error("block not idle after the final character");

    // Only sign, fill and digit characters are produced.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == iff_pkg::CHAR_MINUS ||
                         i_out_char == iff_pkg::CHAR_SPACE ||
                         (i_out_char >= 7'h30 && i_out_char <= 7'h39) ||
                         (i_out_char >= 7'h41 && i_out_char <= 7'h46)))
        else $error("unexpected character code");

    // A stalled character beat holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled character beat changed");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last_char)
);
